@@ rtl/psg_pkg.sv @@
// Package: constants, types and state codes for the prime sieve generator.
`default_nettype none
package psg_pkg;
    localparam int WindowBits = 4096;
    localparam int MaxPrimes  = 4096;
    localparam int ValueWidth = 24;
    localparam int WinAw      = $clog2(WindowBits);
    localparam int StoreAw    = $clog2(MaxPrimes);
    localparam int CountW     = 13;
    localparam int LimitW     = 13;
    localparam logic [LimitW-1:0] LimitReset = 13'd4096;

    typedef logic [ValueWidth-1:0] value_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CHECK,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_FILL,
        ST_REMARK_RD,
        ST_REMARK_DIV,
        ST_MARK,
        ST_RECORD,
        ST_DONE
    } state_t;

    // Multiple-walk request to the mark unit.
    typedef struct packed {
        logic   start;
        value_t step;
        logic [ValueWidth:0] from;
    } mark_req_t;
endpackage
`default_nettype wire

@@ rtl/psg_if.sv @@
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface psg_req_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface psg_rsp_if;
    logic        valid;
    logic        ready;
    logic [23:0] prime_value;
    logic [12:0] prime_position;
    logic        exhausted;
    modport source (output valid, output prime_value, output prime_position,
                    output exhausted, input ready);
    modport sink (input valid, input prime_value, input prime_position,
                  input exhausted, output ready);
endinterface
`default_nettype wire

@@ rtl/psg_divider.sv @@
// Restoring divider: floor(base / q) * q, one quotient bit per cycle.
`default_nettype none
module psg_divider (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [psg_pkg::ValueWidth:0]  dividend,
    input  wire logic [psg_pkg::ValueWidth-1:0] divisor,
    output logic                               done,
    output logic [psg_pkg::ValueWidth:0]       rounded
);
    import psg_pkg::*;
    localparam int DW = ValueWidth + 1;
    localparam int CntW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [ValueWidth-1:0] dsr_reg, dsr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [DW:0] trial;
    logic [DW-1:0] rem_sh;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_sh    = {rem_reg[DW-2:0], quo_reg[DW-1]};
        trial     = {1'b0, rem_sh} - {2'b00, dsr_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CntW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DW])
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    // Quotient times divisor = dividend minus remainder.
    assign done    = busy_reg && (cnt_reg == CntW'(1));
    assign rounded = dividend - rem_next;
endmodule
`default_nettype wire

@@ rtl/psg_mark.sv @@
// Mark unit: walks multiples of a step through the window, one clear per cycle.
`default_nettype none
module psg_mark (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire psg_pkg::mark_req_t              req,
    input  wire logic [psg_pkg::ValueWidth:0]    window_end,
    input  wire logic [psg_pkg::ValueWidth:0]    window_base,
    output logic                                 busy,
    output logic                                 clr_en,
    output logic [psg_pkg::WinAw-1:0]            clr_addr
);
    import psg_pkg::*;
    logic [ValueWidth:0] m_reg, m_next;
    logic [ValueWidth-1:0] step_reg, step_next;
    logic busy_reg, busy_next;
    logic [ValueWidth:0] offs;

    always_comb
    begin
        m_next    = m_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        clr_en    = 1'b0;
        offs      = m_reg - window_base;
        if (req.start)
        begin
            m_next    = req.from;
            step_next = req.step;
            busy_next = (req.from < window_end);
        end
        else if (busy_reg)
        begin
            clr_en = 1'b1;
            m_next = m_reg + {1'b0, step_reg};
            // Stop once the next multiple leaves the window (or wraps).
            if (m_next >= window_end || m_next < m_reg)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        step_reg <= step_next;
    end

    assign busy     = busy_reg;
    assign clr_addr = offs[WinAw-1:0];
endmodule
`default_nettype wire

@@ rtl/prime_sieve_generator.sv @@
// Top level of the prime sieve generator: sequencer, sieve and prime store.
`default_nettype none
// Segmented sieve of Eratosthenes: each request beat returns the next prime and
// its position, or exhausted. One request at a time; ready is low while busy.
// A finished result waits in the output register while the next request is taken;
// a new result is held back until the waiting one has been accepted.
// A request scans the 4096-bit window one entry at a time (ST_SCAN_RD reads, ST_SCAN_EV
// tests), then marks the multiples of the new prime one per cycle. Leaving the window
// refills it with ones, then for each stored prime runs a divide and marks its multiples
// in the window one per cycle. After reset or restart the window is refilled before the
// first scan.
module prime_sieve_generator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [12:0] cfg_wdata,
    psg_req_if.sink          req,
    psg_rsp_if.source        rsp
);
    import psg_pkg::*;
    localparam int VW1 = ValueWidth + 1;
    localparam logic [VW1-1:0] WinSize = VW1'(WindowBits);
    localparam logic [VW1-1:0] ValueMax = {1'b0, {ValueWidth{1'b1}}};

    state_t state_reg, state_next;
    logic [LimitW-1:0] limit_reg;
    logic [VW1-1:0] base_reg, base_next;
    logic [VW1-1:0] pos_reg, pos_next;
    logic [ValueWidth-1:0] last_reg, last_next;
    logic [CountW-1:0] found_reg, found_next;
    logic [CountW-1:0] idx_reg, idx_next;
    logic [WinAw:0] fill_reg, fill_next;
    logic restart_reg, restart_next;
    logic [ValueWidth-1:0] val_reg, val_next;
    logic [CountW-1:0] posn_reg, posn_next;
    logic exh_reg, exh_next;
    logic out_valid_reg, out_valid_next;

    logic sieve_mem [WindowBits];
    logic sieve_rd_reg;
    logic [WinAw-1:0] sieve_rd_addr;
    logic sieve_wr_en, sieve_wr_val;
    logic [WinAw-1:0] sieve_wr_addr;

    logic [ValueWidth-1:0] store_mem [MaxPrimes];
    logic [ValueWidth-1:0] store_rd_reg;
    logic store_we;

    mark_req_t mreq;
    logic mark_busy, mark_clr;
    logic [WinAw-1:0] mark_addr;
    logic div_start, div_done;
    logic [VW1-1:0] div_round;
    logic [VW1-1:0] win_end;
    logic [VW1-1:0] pos_off;

    assign win_end = base_reg + WinSize;
    assign pos_off = pos_reg - base_reg;

    psg_mark u_mark (
        .clk(clk), .rst_n(rst_n), .req(mreq), .window_end(win_end),
        .window_base(base_reg), .busy(mark_busy), .clr_en(mark_clr),
        .clr_addr(mark_addr)
    );

    psg_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(base_reg),
        .divisor(store_rd_reg), .done(div_done), .rounded(div_round)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LimitReset;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (sieve_wr_en)
            sieve_mem[sieve_wr_addr] <= sieve_wr_val;
        sieve_rd_reg <= sieve_mem[sieve_rd_addr];
        if (store_we)
            store_mem[found_reg[StoreAw-1:0]] <= pos_reg[ValueWidth-1:0];
        store_rd_reg <= store_mem[idx_reg[StoreAw-1:0]];
    end

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        found_next     = found_reg;
        idx_next       = idx_reg;
        fill_next      = fill_reg;
        val_next       = val_reg;
        posn_next      = posn_reg;
        exh_next       = exh_reg;
        out_valid_next = out_valid_reg;
        sieve_rd_addr  = pos_off[WinAw-1:0];
        sieve_wr_en    = 1'b0;
        sieve_wr_addr  = mark_addr;
        sieve_wr_val   = 1'b0;
        store_we       = 1'b0;
        div_start      = 1'b0;
        mreq.start     = 1'b0;
        mreq.step      = pos_reg[ValueWidth-1:0];
        mreq.from      = {pos_reg[ValueWidth-1:0], 1'b0};
        req.ready      = 1'b0;

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;
        if (mark_clr)
            sieve_wr_en = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    if (req.restart)
                    begin
                        base_next  = '0;
                        last_next  = ValueWidth'(1);
                        found_next = '0;
                        fill_next  = '0;
                        state_next = ST_CLEAR;
                    end
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_CLEAR:
            begin
                // Refill window with ones; entries zero and one are not prime.
                sieve_wr_en   = 1'b1;
                sieve_wr_addr = fill_reg[WinAw-1:0];
                sieve_wr_val  = (fill_reg > (WinAw+1)'(1));
                fill_next     = fill_reg + 1'b1;
                if (fill_reg == (WinAw+1)'(WindowBits - 1))
                    state_next = restart_reg ? ST_IDLE : ST_CHECK;
            end
            ST_CHECK:
            begin
                pos_next = {1'b0, last_reg} + 1'b1;
                if (found_reg >= limit_reg || found_reg >= CountW'(MaxPrimes))
                    state_next = ST_DONE;
                else
                    state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                if (pos_reg > ValueMax)
                    state_next = ST_DONE;
                else if (pos_reg >= win_end)
                begin
                    base_next  = win_end;
                    fill_next  = '0;
                    state_next = ST_FILL;
                end
                else
                    state_next = ST_SCAN_EV;
            end
            ST_SCAN_EV:
            begin
                if (sieve_rd_reg)
                    state_next = ST_RECORD;
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_FILL:
            begin
                sieve_wr_en   = 1'b1;
                sieve_wr_addr = fill_reg[WinAw-1:0];
                sieve_wr_val  = 1'b1;
                fill_next     = fill_reg + 1'b1;
                idx_next      = '0;
                if (fill_reg == (WinAw+1)'(WindowBits - 1))
                    state_next = ST_REMARK_RD;
            end
            ST_REMARK_RD:
            begin
                if (mark_busy)
                    state_next = ST_REMARK_RD;
                else if (idx_reg >= found_reg)
                    state_next = ST_SCAN_RD;
                else
                    state_next = ST_REMARK_DIV;
            end
            ST_REMARK_DIV:
            begin
                // Store data is registered now; launch divide once.
                if (!div_start && fill_reg != '0)
                begin
                    div_start = 1'b1;
                    fill_next = '0;
                end
                else if (div_done)
                begin
                    mreq.start = (store_rd_reg != '0);
                    mreq.step  = store_rd_reg;
                    mreq.from  = (div_round < base_reg) ?
                                 div_round + {1'b0, store_rd_reg} : div_round;
                    idx_next   = idx_reg + 1'b1;
                    fill_next  = (WinAw+1)'(1);
                    state_next = ST_REMARK_RD;
                end
            end
            ST_RECORD:
            begin
                store_we   = 1'b1;
                found_next = found_reg + 1'b1;
                last_next  = pos_reg[ValueWidth-1:0];
                mreq.start = 1'b1;
                state_next = ST_MARK;
            end
            ST_MARK:
            begin
                // Hold the new result until marking has finished and the previous beat has left.
                if (!mark_busy && !out_valid_reg)
                begin
                    val_next       = last_reg;
                    posn_next      = found_reg;
                    exh_next       = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg)
                begin
                    val_next       = '0;
                    posn_next      = '0;
                    exh_next       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Restart refills the window then runs a normal request.
    always_comb
    begin
        restart_next = restart_reg;
        if (state_reg == ST_IDLE)
            restart_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            base_reg      <= '0;
            last_reg      <= ValueWidth'(1);
            found_reg     <= '0;
            fill_reg      <= '0;
            restart_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            last_reg      <= last_next;
            found_reg     <= found_next;
            fill_reg      <= (state_reg == ST_FILL && state_next == ST_REMARK_RD) ?
                             (WinAw+1)'(1) : fill_next;
            restart_reg   <= restart_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        posn_reg <= posn_next;
        exh_reg  <= exh_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.prime_value    = val_reg;
    assign rsp.prime_position = posn_reg;
    assign rsp.exhausted      = exh_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req.ready)
        else $error("request taken while busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg <= CountW'(MaxPrimes))
        else $error("prime count overflow");
    a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.exhausted) |-> (rsp.prime_value == '0))
        else $error("exhausted result carries a value");
    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready) |=> !rsp.valid)
        else $error("result repeated");
endmodule
`default_nettype wire

@@ dv/psg_tb_if.sv @@
// Testbench copy of nothing new: the channel interfaces come from rtl/psg_if.sv.
`timescale 1ns / 100ps
// Result beat as the checker sees it.
package psg_tb_pkg;
    import psg_pkg::*;
    typedef struct packed {
        value_t      value;
        logic [12:0] position;
        logic        exhausted;
    } prime_rsp_t;
endpackage

@@ dv/tb.sv @@
// Testbench for the prime sieve generator: directed and random requests with a sieve predictor.
`timescale 1ns / 100ps
module tb;
    import psg_pkg::*;
    import psg_tb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [12:0] cfg_wdata;
    psg_req_if   req_ch ();
    psg_rsp_if   rsp_ch ();

    prime_sieve_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // sieve predictor state
    bit          sieve_flag [WindowBits];
    int unsigned prime_store [MaxPrimes];
    longint      win_base;
    longint      last_prime;
    int unsigned prime_count;
    int unsigned limit_reg;

    prime_rsp_t  pending_primes [$];
    int          errors;
    bit          calm;
    int          hold_left;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic void clear_sieve();
        foreach (sieve_flag[i])
            sieve_flag[i] = 1'b1;
        sieve_flag[0] = 1'b0;
        sieve_flag[1] = 1'b0;
        win_base = 0;
        last_prime = 1;
        prime_count = 0;
    endfunction

    function automatic void strike_multiples(longint q, longint from);
        longint m;
        m = from;
        while (m < win_base + WindowBits)
        begin
            if (m >= win_base)
                sieve_flag[m - win_base] = 1'b0;
            m += q;
        end
    endfunction

    function automatic void slide_window();
        longint q;
        longint m;
        win_base += WindowBits;
        foreach (sieve_flag[i])
            sieve_flag[i] = 1'b1;
        for (int i = 0; i < prime_count; i++)
        begin
            q = prime_store[i];
            if (q == 0)
                continue;
            m = (win_base / q) * q;
            if (m < win_base)
                m += q;
            strike_multiples(q, m);
        end
    endfunction

    function automatic prime_rsp_t next_prime(bit restart);
        prime_rsp_t r;
        longint     cand;
        r = '{value: '0, position: '0, exhausted: 1'b1};
        if (restart)
            clear_sieve();
        if (prime_count >= limit_reg || prime_count >= MaxPrimes)
            return r;
        cand = last_prime + 1;
        forever
        begin
            if (cand > (64'd1 << ValueWidth) - 1)
                return r;
            if (cand >= win_base + WindowBits)
            begin
                slide_window();
                continue;
            end
            if (sieve_flag[cand - win_base])
                break;
            cand++;
        end
        prime_store[prime_count] = 32'(cand);
        prime_count++;
        last_prime = cand;
        strike_multiples(cand, cand + cand);
        r.value = cand[ValueWidth-1:0];
        r.position = prime_count[12:0];
        r.exhausted = 1'b0;
        return r;
    endfunction

    task automatic send_req(input bit restart);
        bit hit;
        if (!calm && $urandom_range(0, 99) < 13)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.restart <= restart;
        do
        begin
            @(negedge clk);
            hit = req_ch.ready;
            if (hit)
                pending_primes.push_back(next_prime(restart));
            @(posedge clk);
        end while (!hit);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_primes.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic set_limit(input int unsigned lim);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= lim[12:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        limit_reg = lim[12:0];
    endtask

    // receiver: random stalls unless calm, long hold when asked
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 13);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_primes.size() == 0)
            begin
                $display("%t: unexpected beat value=%0d pos=%0d exh=%0b", $time,
                         rsp_ch.prime_value, rsp_ch.prime_position, rsp_ch.exhausted);
                errors++;
            end
            else
            begin
                prime_rsp_t e;
                e = pending_primes.pop_front();
                if (e.value !== rsp_ch.prime_value)
                begin
                    $display("%t: prime_value exp %0d got %0d", $time, e.value,
                             rsp_ch.prime_value);
                    errors++;
                end
                if (e.position !== rsp_ch.prime_position)
                begin
                    $display("%t: prime_position exp %0d got %0d", $time, e.position,
                             rsp_ch.prime_position);
                    errors++;
                end
                if (e.exhausted !== rsp_ch.exhausted)
                begin
                    $display("%t: exhausted exp %0b got %0b", $time, e.exhausted,
                             rsp_ch.exhausted);
                    errors++;
                end
            end
        end
    end

    task automatic test_first_primes();
        for (int i = 0; i < 8; i++)
            send_req(1'b0);
        send_req(1'b1);
        send_req(1'b0);
    endtask

    task automatic test_limit_extremes();
        set_limit(1);
        send_req(1'b0);
        send_req(1'b0);
        send_req(1'b1);
        send_req(1'b0);
        set_limit(3);
        send_req(1'b0);
        send_req(1'b0);
        send_req(1'b0);
        send_req(1'b1);
        set_limit(4096);
        send_req(1'b1);
    endtask

    // long run with no restart: crosses into the second window
    task automatic test_window_cross();
        calm = 1'b1;
        for (int i = 0; i < 200; i++)
            send_req(1'b0);
        calm = 1'b0;
        for (int i = 0; i < 450; i++)
            send_req(1'b0);
    endtask

    task automatic test_backpressure();
        hold_left = 400;
        for (int i = 0; i < 6; i++)
            send_req(1'b0);
    endtask

    task automatic test_random();
        int unsigned pick;
        for (int chunk = 0; chunk < 14; chunk++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                set_limit(1);
            else if (pick < 3)
                set_limit(4096);
            else
                set_limit($urandom_range(1, 300));
            repeat ($urandom_range(20, 60))
                send_req($urandom_range(0, 24) == 0);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.restart = 1'b0;
        errors = 0;
        calm = 1'b0;
        hold_left = 0;
        limit_reg = LimitReset;
        clear_sieve();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_first_primes();
        test_limit_extremes();
        test_window_cross();
        test_backpressure();
        test_random();
        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("[prime_sieve_generator] OK");
        else
            $display("[prime_sieve_generator] ERROR");
        $finish;
    end

    initial
    begin
        #60000000;
        $display("[prime_sieve_generator] ERROR");
        $finish;
    end
endmodule
